// ===== hdl/tqla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqla_pkg: shared types and constants of the Q-learning agent
// Sequencer states, register indexes, item modes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package tqla_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_UPD_RD,
    ST_UPD_MG,
    ST_UPD_TGT,
    ST_UPD_MH,
    ST_UPD_ML,
    ST_UPD_SUM,
    ST_UPD_WR
  } tqla_state_t;

  // configuration register indexes
  localparam logic [1:0] REG_ACTIONS_IN_USE = 2'd0;
  localparam logic [1:0] REG_EXPLORE_LEVEL  = 2'd1;
  localparam logic [1:0] REG_LEARN_RATE     = 2'd2;
  localparam logic [1:0] REG_FUTURE_WEIGHT  = 2'd3;

  // item modes
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_STEP   = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // register reset values
  localparam logic [2:0]  RST_ACTIONS_IN_USE = 3'd4;
  localparam logic [15:0] RST_EXPLORE_LEVEL  = 16'd6554;
  localparam logic [15:0] RST_LEARN_RATE     = 16'd6554;
  localparam logic [15:0] RST_FUTURE_WEIGHT  = 16'd58982;

  // datapath widths
  localparam int VAL_W  = 16;  // Q8.8 table value
  localparam int TGT_W  = 34;  // update target in Q.24
  localparam int MA_W   = 17;  // multiplier operand a (unsigned Q0.16, sign bit added)
  localparam int MB_W   = 18;  // multiplier operand b
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = 51;  // increment accumulator in Q.40
  localparam int TL_W   = 17;  // low slice of target
  localparam int INC_W  = ACC_W - 32;

  localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(64'sd2147483648);

endpackage

// ===== hdl/tabular_q_learning_agent_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabular_q_learning_agent_unit: tabular Q-learning agent, epsilon-greedy
//
// Issue an item with start while busy is low. A start item returns the action
// for in_state_index; a step item returns the action for the new state and
// then folds reward plus gamma times the best value of the new state into the
// value of the previous (state, action) pair; an end item applies the update
// with no future term and returns nothing. The result appears for exactly one
// cycle on out_action / out_explored, marked by out_valid, and the receiver
// cannot hold it off. After reset the value table is swept to zero, one entry
// a cycle, with busy high. Busy stays high while an item is in work: the
// action scan reads one table entry a cycle from the single read port, over
// the actions in use, and the update passes three products through one shared
// 17x18 multiplier. The configuration port is always ready.
// ----------------------------------------------------------------------------
module tabular_q_learning_agent_unit
  import tqla_pkg::*;
#(
  parameter int STATE_COUNT  = 64,
  parameter int ACTION_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [5:0]         in_state_index,
  input  logic signed [15:0] in_reward,
  input  logic [15:0]        in_random_draw,
  input  logic [1:0]         in_random_action,
  // result output
  output logic               out_valid,
  output logic [1:0]         out_action,
  output logic               out_explored,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int DEPTH  = STATE_COUNT * ACTION_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SW     = $clog2(STATE_COUNT);
  localparam int AW     = $clog2(ACTION_COUNT);
  localparam int CNT_W  = $clog2(ACTION_COUNT + 1);

  // Fold a 6-bit state number into range by restoring subtraction of
  // shifted copies of the state count.
  function automatic logic [5:0] reduce_state(input logic [5:0] x);
    logic [5:0] v;
    int         lim;
    v = x;
    for (int k = 5; k >= 0; k--) begin
      lim = STATE_COUNT << k;
      if (lim <= 63 && int'(v) >= lim) begin
        v = v - 6'(lim);
      end
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  tqla_state_t state_r, state_nxt;

  logic [2:0]  actions_in_use_r, actions_in_use_nxt;
  logic [15:0] explore_level_r, explore_level_nxt;
  logic [15:0] learn_rate_r, learn_rate_nxt;
  logic [15:0] future_weight_r, future_weight_nxt;

  logic [SW-1:0]     last_state_r, last_state_nxt;
  logic [AW-1:0]     last_action_r, last_action_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [AW-1:0]     act_r, act_nxt;      // scan read pointer
  logic              pend_r, pend_nxt;    // a scan read is in flight
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [1:0]              mode_r, mode_nxt;
  logic signed [15:0]      reward_r, reward_nxt;
  logic [15:0]             draw_r, draw_nxt;
  logic [1:0]              ract_r, ract_nxt;
  logic [ADDR_W-1:0]       base_r, base_nxt;
  logic [ADDR_W-1:0]       upd_addr_r, upd_addr_nxt;
  logic [AW-1:0]           pend_act_r, pend_act_nxt;
  logic signed [VAL_W-1:0] best_r, best_nxt;
  logic [AW-1:0]           best_act_r, best_act_nxt;
  logic signed [VAL_W-1:0] maxq_r, maxq_nxt;
  logic signed [VAL_W-1:0] q_r, q_nxt;
  logic signed [TGT_W-1:0] target_r, target_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [1:0]              out_action_r, out_action_nxt;
  logic                    out_explored_r, out_explored_nxt;

  // --------------------------------------------------------------------------
  // table memory
  // --------------------------------------------------------------------------
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  tqla_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // shared multiplier: gamma*maxQ, then alpha times each half of the target
  // --------------------------------------------------------------------------
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_UPD_MG: begin
        mul_a = $signed({1'b0, future_weight_r});
        mul_b = MB_W'(maxq_r);
      end
      ST_UPD_MH: begin
        mul_a = $signed({1'b0, learn_rate_r});
        mul_b = MB_W'($signed(target_r[TGT_W-1:TL_W]));
      end
      ST_UPD_ML: begin
        mul_a = $signed({1'b0, learn_rate_r});
        mul_b = $signed({1'b0, target_r[TL_W-1:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // --------------------------------------------------------------------------
  // datapath helpers
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]        n_eff;       // actions in use, clamped to [1, ACTION_COUNT]
  logic [AW-1:0]           lim_act;
  logic signed [VAL_W-1:0] rd_val;
  logic                    take_rd;
  logic signed [VAL_W-1:0] cmp_best;
  logic [AW-1:0]           cmp_act;
  logic                    explore;
  logic [AW-1:0]           chosen;
  logic signed [INC_W-1:0] inc;
  logic signed [INC_W:0]   nq_wide;
  logic signed [VAL_W-1:0] nq_sat;
  logic [5:0]              s_red;

  always_comb begin
    if (actions_in_use_r == 3'd0) begin
      n_eff = CNT_W'(1);
    end else if (int'(actions_in_use_r) > ACTION_COUNT) begin
      n_eff = CNT_W'(ACTION_COUNT);
    end else begin
      n_eff = CNT_W'(actions_in_use_r);
    end
    lim_act = AW'(n_eff - CNT_W'(1));

    // running argmax; the first action seeds it, ties keep the lower index
    rd_val  = $signed(ram_rdata);
    take_rd = (pend_act_r == '0) || (rd_val > best_r);
    cmp_best = take_rd ? rd_val : best_r;
    cmp_act  = take_rd ? pend_act_r : best_act_r;

    explore = draw_r < explore_level_r;
    if (int'(ract_r) > int'(lim_act)) begin
      chosen = lim_act;
    end else begin
      chosen = AW'(ract_r);
    end
    if (!explore) begin
      chosen = cmp_act;
    end

    // round the Q.40 increment to nearest (half up) and saturate the new value
    inc     = acc_r[ACC_W-1:32];
    nq_wide = (INC_W+1)'(q_r) + (INC_W+1)'(inc);
    if (nq_wide > (INC_W+1)'(32767)) begin
      nq_sat = 16'sh7fff;
    end else if (nq_wide < -(INC_W+1)'(32768)) begin
      nq_sat = -16'sh8000;
    end else begin
      nq_sat = VAL_W'(nq_wide);
    end

    s_red = reduce_state(in_state_index);
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt          = state_r;
    actions_in_use_nxt = actions_in_use_r;
    explore_level_nxt  = explore_level_r;
    learn_rate_nxt     = learn_rate_r;
    future_weight_nxt  = future_weight_r;
    last_state_nxt     = last_state_r;
    last_action_nxt    = last_action_r;
    clr_nxt            = clr_r;
    act_nxt            = act_r;
    pend_nxt           = 1'b0;
    out_valid_nxt      = 1'b0;

    mode_nxt         = mode_r;
    reward_nxt       = reward_r;
    draw_nxt         = draw_r;
    ract_nxt         = ract_r;
    base_nxt         = base_r;
    upd_addr_nxt     = upd_addr_r;
    pend_act_nxt     = pend_act_r;
    best_nxt         = best_r;
    best_act_nxt     = best_act_r;
    maxq_nxt         = maxq_r;
    q_nxt            = q_r;
    target_nxt       = target_r;
    acc_nxt          = acc_r;
    out_action_nxt   = out_action_r;
    out_explored_nxt = out_explored_r;

    ram_we    = 1'b0;
    ram_waddr = upd_addr_r;
    ram_wdata = nq_sat;
    ram_raddr = base_r;

    // configuration writes land whenever they arrive
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACTIONS_IN_USE: actions_in_use_nxt = cfg_data[2:0];
        REG_EXPLORE_LEVEL:  explore_level_nxt  = cfg_data;
        REG_LEARN_RATE:     learn_rate_nxt     = cfg_data;
        REG_FUTURE_WEIGHT:  future_weight_nxt  = cfg_data;
        default:            actions_in_use_nxt = actions_in_use_r;
      endcase
    end

    unique case (state_r)
      ST_CLEAR: begin
        // sweep the table to zero after reset
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          mode_nxt     = in_mode;
          reward_nxt   = in_reward;
          draw_nxt     = in_random_draw;
          ract_nxt     = in_random_action;
          base_nxt     = ADDR_W'(s_red * ACTION_COUNT);
          upd_addr_nxt = ADDR_W'(last_state_r * ACTION_COUNT + last_action_r);
          act_nxt      = '0;
          maxq_nxt     = '0;
          if (in_mode == MODE_START || in_mode == MODE_STEP) begin
            last_state_nxt = SW'(s_red);
            state_nxt      = ST_SCAN;
          end else if (in_mode == MODE_END) begin
            state_nxt = ST_UPD_RD;
          end
        end
      end

      ST_SCAN: begin
        // issue one read per action, fold the previous read into the argmax
        ram_raddr    = base_r + ADDR_W'(act_r);
        pend_nxt     = 1'b1;
        pend_act_nxt = act_r;
        act_nxt      = act_r + AW'(1);
        if (pend_r) begin
          best_nxt     = cmp_best;
          best_act_nxt = cmp_act;
        end
        if (act_r == lim_act) begin
          state_nxt = ST_SCAN_LAST;
        end
      end

      ST_SCAN_LAST: begin
        // last value is in: pick the action, emit the item, remember the pair
        maxq_nxt         = cmp_best;
        last_action_nxt  = chosen;
        out_valid_nxt    = 1'b1;
        out_action_nxt   = 2'(chosen);
        out_explored_nxt = explore;
        if (mode_r == MODE_STEP) begin
          state_nxt = ST_UPD_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_UPD_RD: begin
        ram_raddr = upd_addr_r;
        state_nxt = ST_UPD_MG;
      end

      ST_UPD_MG: begin
        // multiplier takes gamma * maxQ this cycle
        q_nxt     = $signed(ram_rdata);
        state_nxt = ST_UPD_TGT;
      end

      ST_UPD_TGT: begin
        target_nxt = ($signed({{(TGT_W-32){reward_r[15]}}, reward_r, 16'd0}))
                   + TGT_W'(prod_r)
                   - ($signed({{(TGT_W-32){q_r[15]}}, q_r, 16'd0}));
        state_nxt  = ST_UPD_MH;
      end

      ST_UPD_MH: begin
        // multiplier takes alpha * upper target slice
        state_nxt = ST_UPD_ML;
      end

      ST_UPD_ML: begin
        // place upper partial product; multiplier takes alpha * lower slice
        acc_nxt   = (ACC_W'(prod_r) <<< TL_W) + ACC_ROUND;
        state_nxt = ST_UPD_SUM;
      end

      ST_UPD_SUM: begin
        acc_nxt   = acc_r + ACC_W'(prod_r);
        state_nxt = ST_UPD_WR;
      end

      ST_UPD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = upd_addr_r;
        ram_wdata = nq_sat;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      actions_in_use_r <= RST_ACTIONS_IN_USE;
      explore_level_r  <= RST_EXPLORE_LEVEL;
      learn_rate_r     <= RST_LEARN_RATE;
      future_weight_r  <= RST_FUTURE_WEIGHT;
      last_state_r     <= '0;
      last_action_r    <= '0;
      clr_r            <= '0;
      act_r            <= '0;
      pend_r           <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      actions_in_use_r <= actions_in_use_nxt;
      explore_level_r  <= explore_level_nxt;
      learn_rate_r     <= learn_rate_nxt;
      future_weight_r  <= future_weight_nxt;
      last_state_r     <= last_state_nxt;
      last_action_r    <= last_action_nxt;
      clr_r            <= clr_nxt;
      act_r            <= act_nxt;
      pend_r           <= pend_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r         <= mode_nxt;
    reward_r       <= reward_nxt;
    draw_r         <= draw_nxt;
    ract_r         <= ract_nxt;
    base_r         <= base_nxt;
    upd_addr_r     <= upd_addr_nxt;
    pend_act_r     <= pend_act_nxt;
    best_r         <= best_nxt;
    best_act_r     <= best_act_nxt;
    maxq_r         <= maxq_nxt;
    q_r            <= q_nxt;
    target_r       <= target_nxt;
    prod_r         <= mul_p;
    acc_r          <= acc_nxt;
    out_action_r   <= out_action_nxt;
    out_explored_r <= out_explored_nxt;
  end

  // --------------------------------------------------------------------------
  // outputs
  // --------------------------------------------------------------------------
  assign busy         = (state_r != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_action   = out_action_r;
  assign out_explored = out_explored_r;

endmodule

// ===== hdl/tqla_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqla_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tqla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
